// ----- design/overwrite_newest_ring_fifo_core_defines.svh -----
// Assertion macros used by the ring FIFO core design file.
`ifndef OVERWRITE_NEWEST_RING_FIFO_CORE_DEFINES_SVH
`define OVERWRITE_NEWEST_RING_FIFO_CORE_DEFINES_SVH

// Implication in the same cycle, sampled on clk and held off during reset.
`define ONRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, sampled on clk and held off during reset.
`define ONRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/onrf_pkg.sv -----
`timescale 1ns / 1ps

package onrf_pkg;

    // Storage geometry of the word store.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Queue size register and pointers; the size never exceeds sixteen slots.
    localparam int SIZE_W = 5;
    localparam int PTR_W  = SIZE_W - 1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'((DEPTH < 16) ? DEPTH : 16);

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_QUEUE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_GET   = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef struct packed {
        action_t         action;
        logic [31:0]     data_in;
    } req_t;

    typedef struct packed {
        logic [31:0]       data_out;
        logic              was_empty;
        logic              overwrote;
        logic [SIZE_W-1:0] used_count;
        logic              is_full;
        logic              is_empty;
    } rsp_t;

    // Store access issued by the pointer logic for one request.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [PTR_W-1:0]  slot;
        logic [31:0]       wdata;
    } mem_op_t;

    // Status of one request, known when the request is taken.
    typedef struct packed {
        logic              took_word;
        logic              was_empty;
        logic              overwrote;
        logic [SIZE_W-1:0] used_count;
        logic              is_full;
        logic              is_empty;
    } stat_t;

    // A written size of zero means one slot; sizes above the store are clipped.
    function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_MAX)
            r = SIZE_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- design/onrf_ram.sv -----
`timescale 1ns / 1ps

module onrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/onrf_ptr.sv -----
`timescale 1ns / 1ps

// Read and write pointers, the last-slot flag and the size register, with the
// next-state logic for one request.
module onrf_ptr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  onrf_pkg::req_t                req,
    input  logic                          size_we,
    input  logic [onrf_pkg::SIZE_W-1:0]   size_wdata,
    output logic [onrf_pkg::SIZE_W-1:0]   queue_size,
    output onrf_pkg::mem_op_t             mem_op,
    output onrf_pkg::stat_t               stat
);

    logic [onrf_pkg::SIZE_W-1:0] size_reg;
    logic [onrf_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [onrf_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic                        last_reg, last_next;

    logic [onrf_pkg::PTR_W-1:0]  wr_inc, wr_inc2, rd_inc;
    logic [onrf_pkg::SIZE_W-1:0] diff;

    // Advance a pointer by one slot, wrapping at the queue size.
    function automatic logic [onrf_pkg::PTR_W-1:0] wrap_inc(
        input logic [onrf_pkg::PTR_W-1:0]  p,
        input logic [onrf_pkg::SIZE_W-1:0] size
    );
        logic [onrf_pkg::SIZE_W-1:0] s;
        s = {1'b0, p} + onrf_pkg::SIZE_W'(1);
        return (s == size) ? '0 : s[onrf_pkg::PTR_W-1:0];
    endfunction

    assign wr_inc  = wrap_inc(wr_ptr_reg, size_reg);
    assign wr_inc2 = wrap_inc(wr_inc, size_reg);
    assign rd_inc  = wrap_inc(rd_ptr_reg, size_reg);

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        last_next      = last_reg;
        mem_op.we      = 1'b0;
        mem_op.re      = 1'b0;
        mem_op.slot    = wr_ptr_reg;
        mem_op.wdata   = req.data_in;
        stat.took_word = 1'b0;
        stat.was_empty = 1'b0;
        stat.overwrote = 1'b0;

        unique case (req.action)
            onrf_pkg::ACT_PUT:
            begin
                mem_op.we = 1'b1;
                if (wr_inc == rd_ptr_reg)
                begin
                    // The slot under the write pointer is the last free one,
                    // or already holds the newest word.
                    stat.overwrote = last_reg;
                    last_next      = 1'b1;
                end
                else if (last_reg)
                begin
                    mem_op.slot = wr_inc;
                    if (wr_inc2 != rd_ptr_reg)
                    begin
                        last_next   = 1'b0;
                        wr_ptr_next = wr_inc2;
                    end
                    else
                    begin
                        wr_ptr_next = wr_inc;
                    end
                end
                else
                begin
                    wr_ptr_next = wr_inc;
                end
            end
            onrf_pkg::ACT_GET:
            begin
                mem_op.slot = rd_ptr_reg;
                if (wr_ptr_reg != rd_ptr_reg)
                begin
                    mem_op.re      = 1'b1;
                    stat.took_word = 1'b1;
                    rd_ptr_next    = rd_inc;
                end
                else if (last_reg)
                begin
                    mem_op.re      = 1'b1;
                    stat.took_word = 1'b1;
                    last_next      = 1'b0;
                end
                else
                begin
                    stat.was_empty = 1'b1;
                end
            end
            onrf_pkg::ACT_FLUSH:
            begin
                rd_ptr_next = wr_ptr_reg;
                last_next   = 1'b0;
            end
            onrf_pkg::ACT_QUERY:
            begin
            end
            default:
            begin
            end
        endcase

        diff = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
        if (wr_ptr_next < rd_ptr_next)
        begin
            diff = diff + size_reg;
        end
        stat.used_count = diff + onrf_pkg::SIZE_W'(last_next);
        stat.is_full    = (stat.used_count == size_reg);
        stat.is_empty   = (stat.used_count == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= onrf_pkg::SIZE_MAX;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            last_reg   <= 1'b0;
        end
        else if (size_we)
        begin
            size_reg   <= onrf_pkg::limit_size(size_wdata);
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            last_reg   <= 1'b0;
        end
        else if (step)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            last_reg   <= last_next;
        end
    end

    assign queue_size = size_reg;

endmodule

// ----- design/overwrite_newest_ring_fifo_core.sv -----
// Ring FIFO that overwrites its newest word when a put finds it full.
// A taken request waits in S_READ for the word store read, then its response moves into the
// output register once that is free; no new request is taken until then.
// A response may wait in the output register while the next request is taken.
// Reset (rst_n, asynchronous, active low) empties the queue and sets the size to 16.
`timescale 1ns / 1ps
`include "overwrite_newest_ring_fifo_core_defines.svh"

module overwrite_newest_ring_fifo_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel.
    input  logic                            req_valid,
    output logic                            req_ready,
    input  onrf_pkg::req_t                  req,
    // Response channel.
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output onrf_pkg::rsp_t                  rsp,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [onrf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [onrf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [onrf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    // The controller is either free to take a request, or waiting for the
    // store read of the request it just took to land and move to the output.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                            step;
    logic                            size_we;
    logic [onrf_pkg::SIZE_W-1:0]     queue_size;
    onrf_pkg::mem_op_t               mem_op;
    onrf_pkg::stat_t                 stat;
    onrf_pkg::stat_t                 stat_reg;
    logic [onrf_pkg::DATA_WIDTH-1:0] rd_data;
    logic                            load_rsp;
    logic                            rsp_valid_reg, rsp_valid_next;
    onrf_pkg::rsp_t                  rsp_reg;

    // ------------------------------------------------------------------
    // Configuration port. Writes take effect at the access phase; the only
    // register is the queue size, and writing it empties the queue.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign size_we = psel && penable && pwrite && pready
                     && (paddr[2] == onrf_pkg::REG_QUEUE_SIZE);
    assign prdata  = (paddr[2] == onrf_pkg::REG_QUEUE_SIZE)
                     ? onrf_pkg::CFG_DATA_W'(queue_size) : '0;

    // ------------------------------------------------------------------
    // Pointer logic. All pointer and flag updates for a request happen when it is
    // taken, so the store access and the fill status are settled then.
    // ------------------------------------------------------------------
    assign req_ready = (state_reg == S_IDLE);
    assign step      = req_valid && req_ready;

    onrf_ptr u_ptr (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .req        (req),
        .size_we    (size_we),
        .size_wdata (pwdata[onrf_pkg::SIZE_W-1:0]),
        .queue_size (queue_size),
        .mem_op     (mem_op),
        .stat       (stat)
    );

    // ------------------------------------------------------------------
    // Word store. A put writes at the edge that takes the request; a get that
    // takes a word reads at that edge, and the read data holds until the next read.
    // ------------------------------------------------------------------
    onrf_ram #(
        .WIDTH (onrf_pkg::DATA_WIDTH),
        .DEPTH (onrf_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (step && mem_op.we),
        .waddr (onrf_pkg::ADDR_W'(mem_op.slot)),
        .wdata (onrf_pkg::DATA_WIDTH'(mem_op.wdata)),
        .re    (step && mem_op.re),
        .raddr (onrf_pkg::ADDR_W'(mem_op.slot)),
        .rdata (rd_data)
    );

    // Status of the request in flight; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            stat_reg <= stat;
        end
    end

    // ------------------------------------------------------------------
    // Control state machine and output register. In S_READ the response is
    // moved into the output register as soon as that register is free or
    // being drained.
    // ------------------------------------------------------------------
    assign load_rsp = (state_reg == S_READ) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (step)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // A get that took no word reports zero data.
    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_reg.data_out   <= stat_reg.took_word ? 32'(rd_data) : '0;
            rsp_reg.was_empty  <= stat_reg.was_empty;
            rsp_reg.overwrote  <= stat_reg.overwrote;
            rsp_reg.used_count <= stat_reg.used_count;
            rsp_reg.is_full    <= stat_reg.is_full;
            rsp_reg.is_empty   <= stat_reg.is_empty;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ONRF_ASSERT_NXT(a_take_waits_read, step, state_reg == S_READ,
        "taken request did not move to the read wait")
    `ONRF_ASSERT_NXT(a_read_holds, (state_reg == S_READ) && rsp_valid_reg && !rsp_ready,
        (state_reg == S_READ) && rsp_valid_reg, "pending response lost while output stalled")
    `ONRF_ASSERT_IMP(a_empty_get_clean, rsp_valid && rsp.was_empty,
        (rsp.data_out == '0) && !rsp.overwrote && !rsp.is_full, "empty get with data or flags")
    `ONRF_ASSERT_IMP(a_full_not_empty, rsp_valid && rsp.is_full,
        (rsp.used_count != '0) && !rsp.is_empty, "full response with zero count")

endmodule
